// ===== rtl/core/bilinear_coordinate_mapper_top_assert.svh =====
// ============================================================================
// Bilinear coordinate mapper: assertion macros
// Shared macros for concurrent assertions clocked on aclk.
// ============================================================================
`ifndef BILINEAR_COORDINATE_MAPPER_TOP_ASSERT_SVH
`define BILINEAR_COORDINATE_MAPPER_TOP_ASSERT_SVH

// Assertion that is checked only while the block is out of reset.
`define BCM_ASSERT_ACTIVE(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define BCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/bcm_pkg.sv =====
// ============================================================================
// bcm_pkg
// Types, widths, register codes and helpers of the bilinear coordinate mapper.
// ============================================================================
`default_nettype none

package bcm_pkg;

    // Largest image dimension on either axis.
    localparam int MAX_DIM = 4096;

    // Index, size, fraction and intermediate widths.
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = IDX_W + 1;
    localparam int Q_BITS = 11;
    localparam int W_W    = Q_BITS;
    localparam int INV_W  = Q_BITS + 1;
    localparam int STEP_W = IDX_W + Q_BITS;
    localparam int POS_W  = IDX_W + STEP_W;
    localparam int CNT_W  = $clog2(STEP_W);

    // Q11 unity.
    localparam logic [INV_W-1:0] Q_ONE = INV_W'(1 << Q_BITS);

    // Register bus.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // Axis select codes.
    localparam logic OP_COLUMN = 1'b0;
    localparam logic OP_ROW    = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] dest_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] near_index;
        logic [IDX_W-1:0] far_index;
        logic [W_W-1:0]   weight;
        logic [INV_W-1:0] inv_weight;
    } out_item_t;

    // Effective sizes minus one, per axis.
    typedef struct packed {
        logic [IDX_W-1:0] src_last_w;
        logic [IDX_W-1:0] src_last_h;
        logic [IDX_W-1:0] dst_last_w;
        logic [IDX_W-1:0] dst_last_h;
    } dims_t;

    // Q11 source steps per destination index, per axis.
    typedef struct packed {
        logic [STEP_W-1:0] col;
        logic [STEP_W-1:0] row;
    } steps_t;

    // Clamp a size register into 1 .. MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // Clamped size minus one, always within the index width.
    function automatic logic [IDX_W-1:0] size_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        e = eff_size(v) - DIM_W'(1);
        return e[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcm_step_div.sv =====
// ============================================================================
// bcm_step_div
// Restoring divider, one quotient bit per cycle in its run state, that computes the column
// and row steps ((src-1) << 11) / (dst-1) after every register write.
// ============================================================================
`default_nettype none

module bcm_step_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr,
    input  wire bcm_pkg::dims_t dims,
    output bcm_pkg::steps_t     steps,
    output logic                busy
);

    import bcm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              axis_reg, axis_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [STEP_W-1:0] quo_reg;
    logic [IDX_W-1:0]  div_reg;
    logic              zero_reg;
    logic [STEP_W-1:0] step_col_reg, step_row_reg;

    logic [IDX_W:0]    trial;
    logic [IDX_W:0]    diff;
    logic              ge;
    logic [STEP_W-1:0] quo_shift;
    logic              last_bit;
    logic [IDX_W-1:0]  num_sel;
    logic [IDX_W-1:0]  den_sel;

    // Operands of the axis being loaded.
    assign num_sel = axis_reg ? dims.src_last_h : dims.src_last_w;
    assign den_sel = axis_reg ? dims.dst_last_h : dims.dst_last_w;

    // One restoring step: shift in the next numerator bit and try to subtract.
    assign trial     = {rem_reg, quo_reg[STEP_W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign ge        = (trial >= {1'b0, div_reg});
    assign quo_shift = {quo_reg[STEP_W-2:0], ge};
    assign last_bit  = (cnt_reg == CNT_W'(STEP_W - 1));

    // Sequencer: a write restarts at the column axis, then the row axis runs.
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        if (cfg_wr) begin
            state_next = ST_LOAD;
            axis_next  = 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    state_next = ST_RUN;
                end
                ST_RUN: begin
                    if (last_bit) begin
                        if (!axis_reg) begin
                            state_next = ST_LOAD;
                            axis_next  = 1'b1;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            step_col_reg <= '0;
            step_row_reg <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            // Store the finished quotient; a destination size of one gives step 0.
            if (state_reg == ST_RUN && last_bit && !cfg_wr) begin
                if (!axis_reg) begin
                    step_col_reg <= zero_reg ? '0 : quo_shift;
                end else begin
                    step_row_reg <= zero_reg ? '0 : quo_shift;
                end
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            quo_reg  <= {num_sel, Q_BITS'(0)};
            div_reg  <= den_sel;
            zero_reg <= (den_sel == '0);
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end else if (state_reg == ST_RUN) begin
            quo_reg <= quo_shift;
            rem_reg <= ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign steps.col = step_col_reg;
    assign steps.row = step_row_reg;
    assign busy      = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/bcm_map_pipe.sv =====
// ============================================================================
// bcm_map_pipe
// Three-stage mapping pipeline: step select, index times step, then clamp
// and weight split into the output register.
// ============================================================================
`default_nettype none

module bcm_map_pipe (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              hold,
    input  wire bcm_pkg::dims_t    dims,
    input  wire bcm_pkg::steps_t   steps,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bcm_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bcm_pkg::out_item_t     m_data
);

    import bcm_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic              adv1, adv2, adv3;

    logic [IDX_W-1:0]  idx1_reg;
    logic [STEP_W-1:0] step1_reg;
    logic [IDX_W-1:0]  last1_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic [IDX_W-1:0]  last2_reg;
    out_item_t         out3_reg;

    logic [POS_W-1:0]        prod;
    logic [POS_W-Q_BITS-1:0] pos_int;
    logic                    at_end;
    out_item_t               out_calc;

    // Each stage moves when it is empty or the one after it moves.
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1 && !hold;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid && s_ready;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: pick step and last source index for the requested axis.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            idx1_reg  <= s_data.dest_index;
            step1_reg <= (s_data.op == OP_ROW) ? steps.row : steps.col;
            last1_reg <= (s_data.op == OP_ROW) ? dims.src_last_h : dims.src_last_w;
        end
    end

    // Stage 2: source position in Q11.
    assign prod = POS_W'(idx1_reg) * POS_W'(step1_reg);

    always_ff @(posedge aclk) begin
        if (adv2) begin
            pos2_reg  <= prod;
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: clamp to the last source sample and split the weights.
    assign pos_int = pos2_reg[POS_W-1:Q_BITS];
    assign at_end  = (pos_int >= (POS_W-Q_BITS)'(last2_reg));

    always_comb begin
        out_calc.near_index = at_end ? last2_reg : pos_int[IDX_W-1:0];
        out_calc.far_index  = at_end ? last2_reg : pos_int[IDX_W-1:0] + IDX_W'(1);
        out_calc.weight     = at_end ? '0 : pos2_reg[Q_BITS-1:0];
        out_calc.inv_weight = Q_ONE - {1'b0, out_calc.weight};
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            out3_reg <= out_calc;
        end
    end

    assign m_valid = v3_reg;
    assign m_data  = out3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bilinear_coordinate_mapper_top.sv =====
// ============================================================================
// bilinear_coordinate_mapper_top
// Maps a destination row or column index to two source indices and Q11
// bilinear weights for an endpoint-aligned resize.
// ============================================================================
// Usage:
//   Program the four size registers over the APB port (byte addresses 0x0,
//   0x4, 0x8, 0xC: source width, source height, destination width,
//   destination height). Each write restarts the step computation, a
//   bit-serial divider that works through both axes in turn; s_ready is low
//   until it finishes.
//   Send requests on s_valid/s_ready with s_data.op selecting columns (0)
//   or rows (1). Each request yields one result on m_valid/m_ready.
//   A request passes the step select, multiply and clamp pipeline
//   registers in that order before m_valid rises. Throughput is one
//   request per cycle while m_ready is high and no step computation runs.
//   When the receiver holds m_ready low the pipeline fills and then s_ready
//   drops; no request is lost or repeated.
//   Reset sets all sizes to 1 and clears the pipeline; the steps reset to
//   zero, so no divider pass is needed after reset.
// ============================================================================
`default_nettype none

module bilinear_coordinate_mapper_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire bcm_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output bcm_pkg::out_item_t              m_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bcm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcm_pkg::DATA_W-1:0] pwdata,
    output logic      [bcm_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    import bcm_pkg::*;

    logic [DIM_W-1:0] src_width_reg;
    logic [DIM_W-1:0] src_height_reg;
    logic [DIM_W-1:0] dst_width_reg;
    logic [DIM_W-1:0] dst_height_reg;

    logic       cfg_wr;
    logic [1:0] reg_sel;
    dims_t      dims;
    steps_t     steps;
    logic       busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:2];

    // Size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
            dst_width_reg  <= DIM_W'(1);
            dst_height_reg <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DIM_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_SRC_WIDTH:  prdata = DATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = DATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = DATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = DATA_W'(dst_height_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamped sizes minus one.
    assign dims.src_last_w = size_last(src_width_reg);
    assign dims.src_last_h = size_last(src_height_reg);
    assign dims.dst_last_w = size_last(dst_width_reg);
    assign dims.dst_last_h = size_last(dst_height_reg);

    bcm_step_div u_step_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .dims    (dims),
        .steps   (steps),
        .busy    (busy)
    );

    bcm_map_pipe u_map_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hold    (busy),
        .dims    (dims),
        .steps   (steps),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bcm_checker.sv =====
// ============================================================================
// bcm_checker
// Port-level checks of the bilinear coordinate mapper, bound to the top level.
// ============================================================================
`default_nettype none

`include "bilinear_coordinate_mapper_top_assert.svh"

module bcm_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire bcm_pkg::out_item_t  m_data,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic                pready
);

    import bcm_pkg::*;

    logic             cfg_wr;
    logic [INV_W-1:0] weight_sum;
    logic             end_sample;
    logic             stalled;

    // Port conditions used by the checks below.
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign weight_sum = INV_W'(m_data.weight) + m_data.inv_weight;
    assign end_sample = m_valid && (m_data.far_index == m_data.near_index);
    assign stalled    = m_valid && !m_ready;

    // The two weights of a result always add up to Q11 unity.
    `BCM_ASSERT_ACTIVE(a_weight_sum, m_valid |-> (weight_sum == Q_ONE), "weight sum not one")

    // A result that collapses to one sample carries no far weight.
    `BCM_ASSERT_ACTIVE(a_end_weight, end_sample |-> (m_data.weight == '0), "weight at end")

    // A stalled result stays put.
    `BCM_ASSERT_ACTIVE(a_out_hold, stalled |=> (m_valid && $stable(m_data)), "stall broken")

    // A register write blocks new requests while the steps are recomputed.
    `BCM_ASSERT_ACTIVE(a_cfg_block, cfg_wr |=> !s_ready, "request accepted during step update")

    // Reset empties the pipeline.
    `BCM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind bilinear_coordinate_mapper_top bcm_checker u_bcm_checker (.*);

`default_nettype wire
